[hdl/bad_pkg.sv]
// Shared constants and width helpers for the block average downscaler.
// Used by the top level, the front, the back and the checker; depends on nothing.
package bad_pkg;

   localparam int PIXEL_W       = 32;
   localparam int DIM_W         = 13;
   localparam int BS_REG_W      = 5;
   localparam int ROW_W         = 12;
   localparam int HEIGHT_LIMIT  = 4096;
   localparam int DIM_NUM_W     = 14;
   localparam int FIFO_DEPTH    = 4;

   localparam int DEF_MAX_WIDTH = 4096;
   localparam int DEF_MAX_BLOCK = 16;

   localparam int CSR_DATA_W    = 13;
   localparam int CSR_IDX_W     = 2;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;

   localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = 13'd4096;
   localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = 13'd4096;
   localparam logic [BS_REG_W-1:0] RST_BLOCK_SIZE   = 5'd2;

   function automatic int cnt_width(input int max_block);
      cnt_width = $clog2(max_block * max_block + 1);
   endfunction

   function automatic int sum_width(input int max_block);
      sum_width = PIXEL_W + cnt_width(max_block);
   endfunction

endpackage

[hdl/block_average_downscale.sv]
// Top level of the block average downscaler: front, queue and back.
// Depends on bad_pkg, bad_front, bad_fifo and bad_back.
//
// Pixels enter in raster order on the req_ queue port (req_push, req_full,
// req_pixel). Each completed block of block_size x block_size pixels (partial
// at the right and bottom edges) produces one result on the rsp_ queue port:
// the block average truncated toward zero, the shrunk image size and a flag
// on the final block of the image. Configuration registers are written on
// the csr_ port; a write to a known index restarts the image at its top left.
// The front takes one pixel per cycle unless req_full is high: after reset
// and after each write to a known index while the shrunk dimensions are
// computed, while the queue is full at the last pixel of a block, and at the
// start of each block segment in a row below the top row of its block, where
// the partial sum of that block column is read back from the accumulator RAM.
// The one bit per cycle divider in the back part takes a new block sum only
// after the last one is done and so sets the sustained result rate. A four
// entry queue and the output register let the front keep accepting while the
// consumer stalls. The accumulator RAM is not cleared; each entry is written
// by the top row of its block before use.
module block_average_downscale #(
   parameter int MAX_WIDTH = bad_pkg::DEF_MAX_WIDTH,
   parameter int MAX_BLOCK = bad_pkg::DEF_MAX_BLOCK
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [bad_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bad_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [bad_pkg::PIXEL_W-1:0] req_pixel,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [bad_pkg::PIXEL_W-1:0] rsp_average,
   output logic [bad_pkg::DIM_W-1:0]          rsp_out_width,
   output logic [bad_pkg::DIM_W-1:0]          rsp_out_height,
   output logic                               rsp_last_of_image
);

   localparam int ITEM_W = bad_pkg::sum_width(MAX_BLOCK) + bad_pkg::cnt_width(MAX_BLOCK) + 1;

   logic              fifo_push, fifo_full, fifo_pop, fifo_empty;
   logic [ITEM_W-1:0] fifo_in_data, fifo_out_data;

   bad_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_BLOCK(MAX_BLOCK)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pixel        (req_pixel),
      .fifo_push        (fifo_push),
      .fifo_data        (fifo_in_data),
      .fifo_full        (fifo_full),
      .out_width        (rsp_out_width),
      .out_height       (rsp_out_height)
   );

   bad_fifo #(.WIDTH(ITEM_W), .DEPTH(bad_pkg::FIFO_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_in_data),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (fifo_out_data),
      .empty     (fifo_empty)
   );

   bad_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
      .clock             (clock),
      .reset             (reset),
      .fifo_empty        (fifo_empty),
      .fifo_data         (fifo_out_data),
      .fifo_pop          (fifo_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_average       (rsp_average),
      .rsp_last_of_image (rsp_last_of_image)
   );

endmodule

[hdl/bad_udiv.sv]
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Uses no package; instantiated by the front and back parts.
module bad_udiv #(
   parameter int N_W = 14,
   parameter int D_W = 5
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           busy,
   output logic [N_W-1:0] quotient
);

   localparam int STEP_W = $clog2(N_W + 1);

   logic [D_W-1:0]    rem_ff, rem_in;
   logic [N_W-1:0]    quo_ff, quo_in;
   logic [D_W-1:0]    den_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [D_W:0]      trial;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[N_W-1]};
      ge      = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? D_W'(trial - {1'b0, den_ff}) : trial[D_W-1:0];
         quo_in  = {quo_ff[N_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(N_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[hdl/bad_fifo.sv]
// Short register queue between the accumulating front and the dividing back.
// Uses no package.
module bad_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/bad_front.sv]
// Front part: configuration registers, raster position tracking and the
// per block column accumulators. Depends on bad_pkg and bad_udiv.
module bad_front #(
   parameter int MAX_WIDTH = bad_pkg::DEF_MAX_WIDTH,
   parameter int MAX_BLOCK = bad_pkg::DEF_MAX_BLOCK,
   localparam int CNT_W    = bad_pkg::cnt_width(MAX_BLOCK),
   localparam int SUM_W    = bad_pkg::sum_width(MAX_BLOCK),
   localparam int ITEM_W   = SUM_W + CNT_W + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [bad_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bad_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic signed [bad_pkg::PIXEL_W-1:0] req_pixel,
   output logic                             fifo_push,
   output logic [ITEM_W-1:0]                fifo_data,
   input  logic                             fifo_full,
   output logic [bad_pkg::DIM_W-1:0]        out_width,
   output logic [bad_pkg::DIM_W-1:0]        out_height
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = COL_W + 1;
   localparam int BLK_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int BS_W  = $clog2(MAX_BLOCK + 1);
   localparam int ROW_W = bad_pkg::ROW_W;
   localparam int DIM_W = bad_pkg::DIM_W;
   localparam int NUM_W = bad_pkg::DIM_NUM_W;

   logic [DIM_W-1:0]             cfg_width_ff, cfg_height_ff;
   logic [bad_pkg::BS_REG_W-1:0] cfg_block_ff;
   logic                         dims_go_ff;

   logic [COL_W-1:0] col_pos_ff, bcol_ff;
   logic [ROW_W-1:0] row_pos_ff;
   logic [BLK_W-1:0] cib_ff, rib_ff;
   logic             loaded_ff;

   logic signed [SUM_W-1:0] acc_sum_ff;
   logic [CNT_W-1:0]        acc_cnt_ff;
   logic [SUM_W+CNT_W-1:0]  acc_mem [MAX_WIDTH];
   logic [SUM_W+CNT_W-1:0]  rd_ff;

   logic [WID_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [BS_W-1:0]  bs_eff;
   logic [BLK_W-1:0] bs_m1;
   logic             last_col, last_row, seg_end, block_done;
   logic             need_fetch, dims_ready, accept, cfg_hit;
   logic             busy_w, busy_h;
   logic [NUM_W-1:0] w_num, h_num, w_quo, h_quo;
   logic signed [SUM_W-1:0] base_sum, new_sum;
   logic [CNT_W-1:0]        base_cnt, new_cnt;

   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = WID_W'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (32'(cfg_height_ff) > 32'(bad_pkg::HEIGHT_LIMIT)) begin
         h_eff = DIM_W'(bad_pkg::HEIGHT_LIMIT);
      end else begin
         h_eff = cfg_height_ff;
      end
      if (cfg_block_ff == '0) begin
         bs_eff = BS_W'(1);
      end else if (32'(cfg_block_ff) > 32'(MAX_BLOCK)) begin
         bs_eff = BS_W'(MAX_BLOCK);
      end else begin
         bs_eff = BS_W'(cfg_block_ff);
      end
   end

   assign bs_m1      = BLK_W'(bs_eff - BS_W'(1));
   assign last_col   = ({1'b0, col_pos_ff} == (w_eff - WID_W'(1)));
   assign last_row   = ({1'b0, row_pos_ff} == (h_eff - DIM_W'(1)));
   assign seg_end    = (cib_ff == bs_m1) || last_col;
   assign block_done = seg_end && ((rib_ff == bs_m1) || last_row);

   assign w_num = NUM_W'(w_eff) + NUM_W'(bs_eff) - NUM_W'(1);
   assign h_num = NUM_W'(h_eff) + NUM_W'(bs_eff) - NUM_W'(1);

   bad_udiv #(.N_W(NUM_W), .D_W(BS_W)) u_width_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dims_go_ff),
      .dividend (w_num),
      .divisor  (bs_eff),
      .busy     (busy_w),
      .quotient (w_quo)
   );

   bad_udiv #(.N_W(NUM_W), .D_W(BS_W)) u_height_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dims_go_ff),
      .dividend (h_num),
      .divisor  (bs_eff),
      .busy     (busy_h),
      .quotient (h_quo)
   );

   assign out_width  = w_quo[DIM_W-1:0];
   assign out_height = h_quo[DIM_W-1:0];

   assign dims_ready = !dims_go_ff && !busy_w && !busy_h;
   assign need_fetch = (cib_ff == '0) && (rib_ff != '0) && !loaded_ff;
   assign req_full   = !dims_ready || need_fetch || (block_done && fifo_full);
   assign accept     = req_push && !req_full;
   assign cfg_hit    = csr_write_enable && ((csr_index == bad_pkg::REG_IMAGE_WIDTH) ||
                       (csr_index == bad_pkg::REG_IMAGE_HEIGHT) ||
                       (csr_index == bad_pkg::REG_BLOCK_SIZE));

   always_comb begin
      if (cib_ff != '0) begin
         base_sum = acc_sum_ff;
         base_cnt = acc_cnt_ff;
      end else if (rib_ff == '0) begin
         base_sum = '0;
         base_cnt = '0;
      end else begin
         base_sum = signed'(rd_ff[CNT_W +: SUM_W]);
         base_cnt = rd_ff[CNT_W-1:0];
      end
      new_sum = base_sum + SUM_W'(req_pixel);
      new_cnt = base_cnt + CNT_W'(1);
   end

   assign fifo_push = accept && block_done;
   assign fifo_data = {last_col && last_row, new_sum, new_cnt};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= bad_pkg::RST_IMAGE_WIDTH;
         cfg_height_ff <= bad_pkg::RST_IMAGE_HEIGHT;
         cfg_block_ff  <= bad_pkg::RST_BLOCK_SIZE;
         dims_go_ff    <= 1'b1;
         col_pos_ff    <= '0;
         row_pos_ff    <= '0;
         cib_ff        <= '0;
         rib_ff        <= '0;
         bcol_ff       <= '0;
         loaded_ff     <= 1'b0;
      end else begin
         dims_go_ff <= cfg_hit;
         if (csr_write_enable) begin
            unique case (csr_index)
               bad_pkg::REG_IMAGE_WIDTH:  cfg_width_ff  <= csr_write_data;
               bad_pkg::REG_IMAGE_HEIGHT: cfg_height_ff <= csr_write_data;
               bad_pkg::REG_BLOCK_SIZE:
                  cfg_block_ff <= csr_write_data[bad_pkg::BS_REG_W-1:0];
               default: ;
            endcase
         end
         if (cfg_hit) begin
            col_pos_ff <= '0;
            row_pos_ff <= '0;
            cib_ff     <= '0;
            rib_ff     <= '0;
            bcol_ff    <= '0;
            loaded_ff  <= 1'b0;
         end else if (need_fetch) begin
            loaded_ff <= 1'b1;
         end else if (accept) begin
            if (seg_end) begin
               loaded_ff <= 1'b0;
            end
            if (last_col) begin
               col_pos_ff <= '0;
               cib_ff     <= '0;
               bcol_ff    <= '0;
               if (last_row) begin
                  row_pos_ff <= '0;
                  rib_ff     <= '0;
               end else begin
                  row_pos_ff <= row_pos_ff + ROW_W'(1);
                  rib_ff     <= (rib_ff == bs_m1) ? '0 : rib_ff + BLK_W'(1);
               end
            end else begin
               col_pos_ff <= col_pos_ff + COL_W'(1);
               if (cib_ff == bs_m1) begin
                  cib_ff  <= '0;
                  bcol_ff <= bcol_ff + COL_W'(1);
               end else begin
                  cib_ff <= cib_ff + BLK_W'(1);
               end
            end
         end
      end
      if (accept) begin
         acc_sum_ff <= new_sum;
         acc_cnt_ff <= new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && seg_end) begin
         acc_mem[bcol_ff] <= {new_sum, new_cnt};
      end
   end

   always_ff @(posedge clock) begin
      if (need_fetch) begin
         rd_ff <= acc_mem[bcol_ff];
      end
   end

endmodule

[hdl/bad_back.sv]
// Back part: takes finished block sums from the queue, divides by the pixel
// count and holds the result for the consumer. Depends on bad_pkg and bad_udiv.
module bad_back #(
   parameter int MAX_BLOCK = bad_pkg::DEF_MAX_BLOCK,
   localparam int CNT_W    = bad_pkg::cnt_width(MAX_BLOCK),
   localparam int SUM_W    = bad_pkg::sum_width(MAX_BLOCK),
   localparam int ITEM_W   = SUM_W + CNT_W + 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fifo_empty,
   input  logic [ITEM_W-1:0]                   fifo_data,
   output logic                                fifo_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [bad_pkg::PIXEL_W-1:0]  rsp_average,
   output logic                                rsp_last_of_image
);

   localparam int PIX_W = bad_pkg::PIXEL_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [SUM_W-1:0] mag_ff, mag_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             last_ff, last_in;
   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] out_avg_ff, out_avg_in;
   logic             out_last_ff, out_last_in;

   logic [SUM_W-1:0] head_sum;
   logic [SUM_W-1:0] quotient;
   logic [PIX_W-1:0] quo_low;
   logic             div_busy, load_out;

   assign head_sum = fifo_data[CNT_W +: SUM_W];
   assign quo_low  = quotient[PIX_W-1:0];
   assign fifo_pop = (state_ff == ST_IDLE) && !fifo_empty;
   assign load_out = (state_ff == ST_DONE) && (!out_valid_ff || rsp_pop);

   bad_udiv #(.N_W(SUM_W), .D_W(CNT_W)) u_avg_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_START),
      .dividend (mag_ff),
      .divisor  (cnt_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff;
      out_avg_in   = out_avg_ff;
      out_last_in  = out_last_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               neg_in   = head_sum[SUM_W-1];
               mag_in   = head_sum[SUM_W-1] ? (~head_sum + SUM_W'(1)) : head_sum;
               cnt_in   = fifo_data[CNT_W-1:0];
               last_in  = fifo_data[ITEM_W-1];
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               out_valid_in = 1'b1;
               out_avg_in   = neg_ff ? (~quo_low + PIX_W'(1)) : quo_low;
               out_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      mag_ff      <= mag_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      last_ff     <= last_in;
      out_avg_ff  <= out_avg_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_average       = signed'(out_avg_ff);
   assign rsp_last_of_image = out_last_ff;

endmodule

[hdl/bad_checker.sv]
// Port level checks for the block average downscaler, bound to its top level.
// Depends on bad_pkg and block_average_downscale.
module bad_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               csr_write_enable,
   input logic [bad_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic                               req_full,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input logic signed [bad_pkg::PIXEL_W-1:0] rsp_average,
   input logic                               rsp_last_of_image
);

   // After reset no result is pending and the input waits for the dimensions.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (rsp_empty && req_full))
      else $error("reset did not leave the block empty and stalled");

   // A write to a known register restarts the dimension computation.
   a_cfg_stalls: assert property (@(posedge clock) disable iff (reset)
      (csr_write_enable && ((csr_index == bad_pkg::REG_IMAGE_WIDTH) ||
                            (csr_index == bad_pkg::REG_IMAGE_HEIGHT) ||
                            (csr_index == bad_pkg::REG_BLOCK_SIZE))) |=> req_full)
      else $error("input not stalled after a register write");

   // A waiting result is neither lost nor altered before its transfer.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_average) && $stable(rsp_last_of_image)))
      else $error("waiting result changed before its transfer");

endmodule

bind block_average_downscale bad_checker u_checker (.*);

[sim/tb_block_average_downscale.sv]
`timescale 1ns / 1ps
// Self-checking testbench for block_average_downscale: a directed table, then random images.
// Depends on bad_pkg and the RTL of block_average_downscale.
// Expected results come from a local predictor, or from the table for directed checked pixels.
module tb_block_average_downscale;

   localparam int unsigned MAX_W        = bad_pkg::DEF_MAX_WIDTH;
   localparam int unsigned MAX_BS       = bad_pkg::DEF_MAX_BLOCK;
   localparam int unsigned MAX_H        = bad_pkg::HEIGHT_LIMIT;
   localparam int          DIM_W        = bad_pkg::DIM_W;
   localparam int          CSR_W        = bad_pkg::CSR_DATA_W;
   localparam int          SETTLE_CYCLES = 120;
   localparam int          CYCLE_LIMIT   = 3000000;
   localparam int          PHASE_PIXELS  = 325;

   localparam logic [bad_pkg::CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam logic signed [31:0] PIX_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] PIX_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [bad_pkg::PIXEL_W-1:0] average;
      logic [bad_pkg::DIM_W-1:0]          out_width;
      logic [bad_pkg::DIM_W-1:0]          out_height;
      logic                               last_of_image;
   } avg_result_type;

   typedef struct packed {
      bit                                 is_write;
      logic [bad_pkg::CSR_IDX_W-1:0]      index;
      logic [bad_pkg::CSR_DATA_W-1:0]     data;
      logic signed [bad_pkg::PIXEL_W-1:0] pixel;
      bit                                 given;
      avg_result_type                     result;
   } stim_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_write_enable = 1'b0;
   logic [bad_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [bad_pkg::CSR_DATA_W-1:0]     csr_write_data = '0;
   logic                               req_push = 1'b0;
   logic                               req_full;
   logic signed [bad_pkg::PIXEL_W-1:0] req_pixel = '0;
   logic                               rsp_empty;
   logic                               rsp_pop = 1'b0;
   logic signed [bad_pkg::PIXEL_W-1:0] rsp_average;
   logic [bad_pkg::DIM_W-1:0]          rsp_out_width;
   logic [bad_pkg::DIM_W-1:0]          rsp_out_height;
   logic                               rsp_last_of_image;

   block_average_downscale dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_pixel         (req_pixel),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_average       (rsp_average),
      .rsp_out_width     (rsp_out_width),
      .rsp_out_height    (rsp_out_height),
      .rsp_last_of_image (rsp_last_of_image)
   );

   // Predictor state.
   logic [bad_pkg::DIM_W-1:0]    cfg_width  = bad_pkg::RST_IMAGE_WIDTH;
   logic [bad_pkg::DIM_W-1:0]    cfg_height = bad_pkg::RST_IMAGE_HEIGHT;
   logic [bad_pkg::BS_REG_W-1:0] cfg_block  = bad_pkg::RST_BLOCK_SIZE;
   longint                       acc_sum [0:MAX_W-1];
   int unsigned                  acc_cnt [0:MAX_W-1];
   int unsigned                  col = 0;
   int unsigned                  row = 0;
   int unsigned                  col_in_blk = 0;
   int unsigned                  row_in_blk = 0;
   int unsigned                  blk_col = 0;

   avg_result_type block_averages_due[$];
   stim_row_type   directed_rows[$];
   int             mismatches = 0;
   int             cycle_count = 0;
   int             send_idle = 0;
   int             recv_stall = 0;
   bit             pushed_since_write = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic restart_position();
      col = 0;
      row = 0;
      col_in_blk = 0;
      row_in_blk = 0;
      blk_col = 0;
   endtask

   task automatic apply_csr(input logic [bad_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bad_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         bad_pkg::REG_IMAGE_WIDTH: begin
            cfg_width = data;
            restart_position();
         end
         bad_pkg::REG_IMAGE_HEIGHT: begin
            cfg_height = data;
            restart_position();
         end
         bad_pkg::REG_BLOCK_SIZE: begin
            cfg_block = data[bad_pkg::BS_REG_W-1:0];
            restart_position();
         end
         default: ;
      endcase
   endtask

   task automatic downscale_pixel(input logic signed [bad_pkg::PIXEL_W-1:0] pix,
                                  output bit hit, output avg_result_type res);
      int unsigned w;
      int unsigned h;
      int unsigned bs;
      int unsigned bc;
      bit          last_col;
      bit          last_row;
      longint      quot;
      w   = clamp_dim(32'(cfg_width), MAX_W);
      h   = clamp_dim(32'(cfg_height), MAX_H);
      bs  = clamp_dim(32'(cfg_block), MAX_BS);
      hit = 1'b0;
      res = '0;
      if (col >= w || row >= h) restart_position();
      bc = blk_col % MAX_W;
      if (row_in_blk == 0 && col_in_blk == 0) begin
         acc_sum[bc] = longint'(pix);
         acc_cnt[bc] = 1;
      end else begin
         acc_sum[bc] = acc_sum[bc] + longint'(pix);
         acc_cnt[bc] = acc_cnt[bc] + 1;
      end
      last_col = (col == w - 1);
      last_row = (row == h - 1);
      if ((col_in_blk == bs - 1 || last_col) && (row_in_blk == bs - 1 || last_row)) begin
         quot              = acc_sum[bc] / longint'(acc_cnt[bc]);
         res.average       = quot[31:0];
         res.out_width     = DIM_W'((w + bs - 1) / bs);
         res.out_height    = DIM_W'((h + bs - 1) / bs);
         res.last_of_image = last_col && last_row;
         hit               = 1'b1;
      end
      if (last_col) begin
         col = 0;
         col_in_blk = 0;
         blk_col = 0;
         if (last_row) begin
            row = 0;
            row_in_blk = 0;
         end else begin
            row++;
            row_in_blk = (row_in_blk == bs - 1) ? 0 : row_in_blk + 1;
         end
      end else begin
         col++;
         if (col_in_blk == bs - 1) begin
            col_in_blk = 0;
            blk_col++;
         end else begin
            col_in_blk++;
         end
      end
   endtask

   task automatic push_pixel(input logic signed [bad_pkg::PIXEL_W-1:0] pix,
                             input bit given, input avg_result_type typed);
      bit             hit;
      avg_result_type res;
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push  <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (req_full !== 1'b0);
      downscale_pixel(pix, hit, res);
      if (given) block_averages_due.push_back(typed);
      else if (hit) block_averages_due.push_back(res);
      pushed_since_write = 1'b1;
   endtask

   task automatic settle_block();
      req_push <= 1'b0;
      while (block_averages_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      pushed_since_write = 1'b0;
   endtask

   task automatic write_csr(input logic [bad_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bad_pkg::CSR_DATA_W-1:0] data);
      if (pushed_since_write) settle_block();
      while (req_full !== 1'b0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      apply_csr(idx, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_write(input logic [bad_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bad_pkg::CSR_DATA_W-1:0] data);
      stim_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.index = idx;
      r.data = data;
      directed_rows.push_back(r);
   endtask

   task automatic add_pixel(input logic signed [bad_pkg::PIXEL_W-1:0] pix);
      stim_row_type r;
      r = '0;
      r.pixel = pix;
      directed_rows.push_back(r);
   endtask

   task automatic add_checked(input logic signed [bad_pkg::PIXEL_W-1:0] pix,
                              input logic signed [bad_pkg::PIXEL_W-1:0] avg,
                              input int unsigned ow, input int unsigned oh, input bit last);
      stim_row_type r;
      r = '0;
      r.pixel = pix;
      r.given = 1'b1;
      r.result.average = avg;
      r.result.out_width = DIM_W'(ow);
      r.result.out_height = DIM_W'(oh);
      r.result.last_of_image = last;
      directed_rows.push_back(r);
   endtask

   task automatic push_random_pixels(input int n, input int mode, inout int count);
      logic signed [bad_pkg::PIXEL_W-1:0] pix;
      for (int k = 0; k < n; k++) begin
         case (mode)
            0: pix = PIX_MAX;
            1: pix = PIX_MIN;
            2: pix = int'($urandom_range(16)) - 8;
            default: pix = $urandom;
         endcase
         push_pixel(pix, 1'b0, '0);
         count++;
      end
   endtask

   task automatic run_image(inout int count);
      int unsigned w;
      int unsigned h;
      int unsigned bs;
      int unsigned bs_raw;
      int unsigned r;
      int          n;
      int          shape;
      w = clamp_dim(32'(cfg_width), MAX_W);
      h = clamp_dim(32'(cfg_height), MAX_H);
      if ($urandom_range(4) != 0 || w * h > 400) begin
         r = $urandom_range(9);
         if (r < 5) bs_raw = $urandom_range(1, 4);
         else if (r < 7) bs_raw = $urandom_range(5, 16);
         else if (r == 7) bs_raw = 16;
         else if (r == 8) bs_raw = ($urandom_range(1) != 0) ? 0 : $urandom_range(17, 31);
         else bs_raw = $urandom_range(1, 16);
         bs = clamp_dim(bs_raw, MAX_BS);
         w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 20);
         if ($urandom_range(19) == 0) h = 0;
         else h = (bs > 8) ? $urandom_range(1, 17) : $urandom_range(1, 8);
         write_csr(bad_pkg::REG_IMAGE_WIDTH, CSR_W'(w));
         write_csr(bad_pkg::REG_IMAGE_HEIGHT, CSR_W'(h));
         write_csr(bad_pkg::REG_BLOCK_SIZE, {8'($urandom), 5'(bs_raw)});
         if ($urandom_range(7) == 0) write_csr(REG_SPARE, CSR_W'($urandom));
         w = clamp_dim(w, MAX_W);
         h = clamp_dim(h, MAX_H);
      end
      shape = $urandom_range(9);
      if (shape < 8) n = w * h;
      else if (shape == 8) n = w * h + $urandom_range(1, w * h);
      else n = $urandom_range(1, w * h);
      push_random_pixels(n, $urandom_range(9), count);
   endtask

   always @(posedge clock) begin
      avg_result_type want;
      avg_result_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         if (!reset && rsp_pop && !rsp_empty) begin
            got.average       = rsp_average;
            got.out_width     = rsp_out_width;
            got.out_height    = rsp_out_height;
            got.last_of_image = rsp_last_of_image;
            if (block_averages_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: average %0d width %0d height %0d last %0b",
                           got.average, got.out_width, got.out_height, got.last_of_image);
            end else begin
               want = block_averages_due.pop_front();
               if (got.average !== want.average || got.out_width !== want.out_width ||
                   got.out_height !== want.out_height ||
                   got.last_of_image !== want.last_of_image) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                              want.average, want.out_width, want.out_height,
                              want.last_of_image, got.average, got.out_width,
                              got.out_height, got.last_of_image);
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall);
      end
   end

   initial begin
      int phase_pixels;
      // Directed table. The first pixels run at the reset geometry and complete no block.
      add_pixel(1);
      add_pixel(2);
      add_pixel(3);
      add_write(bad_pkg::REG_IMAGE_WIDTH, 1);
      add_write(bad_pkg::REG_IMAGE_HEIGHT, 1);
      add_write(bad_pkg::REG_BLOCK_SIZE, 1);
      add_checked(PIX_MAX, PIX_MAX, 1, 1, 1);
      add_checked(PIX_MIN, PIX_MIN, 1, 1, 1);
      add_checked(0, 0, 1, 1, 1);
      add_checked(-1, -1, 1, 1, 1);
      add_write(bad_pkg::REG_IMAGE_WIDTH, 0);
      add_write(bad_pkg::REG_IMAGE_HEIGHT, 0);
      add_write(bad_pkg::REG_BLOCK_SIZE, 13'h1FE0);
      add_checked(-5, -5, 1, 1, 1);
      add_write(bad_pkg::REG_IMAGE_WIDTH, 3);
      add_write(bad_pkg::REG_IMAGE_HEIGHT, 1);
      add_write(bad_pkg::REG_BLOCK_SIZE, 2);
      add_pixel(-3);
      add_checked(-4, -3, 2, 1, 0);
      add_checked(7, 7, 2, 1, 1);
      add_write(bad_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
      add_write(bad_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
      add_write(bad_pkg::REG_BLOCK_SIZE, 31);
      add_pixel(PIX_MAX);
      add_pixel(PIX_MAX);
      add_write(REG_SPARE, 13'h1FFF);
      add_pixel(PIX_MIN);
      add_write(bad_pkg::REG_IMAGE_WIDTH, 2);
      add_write(bad_pkg::REG_IMAGE_HEIGHT, 3);
      add_write(bad_pkg::REG_BLOCK_SIZE, 2);
      add_pixel(10);
      add_pixel(11);
      add_pixel(12);
      add_checked(13, 11, 1, 2, 0);
      add_pixel(20);
      add_checked(21, 20, 1, 2, 1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write)
            write_csr(directed_rows[i].index, directed_rows[i].data);
         else
            push_pixel(directed_rows[i].pixel, directed_rows[i].given,
                       directed_rows[i].result);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 75; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 75; end
            default: begin send_idle = 22; recv_stall = 22; end
         endcase
         phase_pixels = 0;
         while (phase_pixels < PHASE_PIXELS) run_image(phase_pixels);
      end

      settle_block();
      if (mismatches == 0 && block_averages_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
